/* hdl/cpsf_pkg.sv */
// Shared types and constants for the correlation peak sub-pixel fit block.
// Holds sizes, register indexes, controller states and command/status words.
// No dependencies.
`timescale 1ns / 1ps

package cpsf_pkg;

  // Map geometry and store sizing
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Field widths
  localparam int CORR_W    = 16;
  localparam int AXIS_W    = 24;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_PIXEL  = 2'd2;

  // Serial divider sizing
  localparam int DIV_NW    = 64;
  localparam int DIV_DW    = 48;
  localparam int DIV_CNT_W = $clog2(DIV_NW);

  // Sub-pixel offsets saturate here; anything larger clamps to an axis mark anyway.
  localparam int OFF_W     = 27;
  localparam int OFF_LIM   = 1 << 25;

  // Step counter shared by the sequenced phases
  localparam int STEP_W    = 4;
  localparam int READ_LAST = 9;

  typedef enum logic [1:0] {
    DIV_OX,
    DIV_OY,
    DIV_RATIO,
    DIV_ROWCOL
  } div_sel_t;

  // The nine samples around the peak: M is minus one, P plus one, row first
  typedef enum logic [3:0] {
    CELL_00,
    CELL_M0,
    CELL_P0,
    CELL_0M,
    CELL_0P,
    CELL_PP,
    CELL_PM,
    CELL_MP,
    CELL_MM
  } cell_sel_t;

  typedef enum logic [3:0] {
    MUL_HXX_HYY,
    MUL_HXY_SQ,
    MUL_HYY_GX,
    MUL_HXY_GY,
    MUL_HXX_GY,
    MUL_HXY_GX,
    MUL_NX_HI,
    MUL_NX_LO,
    MUL_NY_HI,
    MUL_NY_LO,
    MUL_RATIO
  } mul_sel_t;

  localparam int MUL_N = 11;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_READ,
    ST_DERIV,
    ST_MUL,
    ST_COMB,
    ST_RMUL,
    ST_COMB2,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN,
    ST_WSTART,
    ST_WWAIT
  } state_t;

  typedef struct packed {
    logic      sample_en;
    logic      fit_clr;
    logic      rd_en;
    cell_sel_t rd_sel;
    logic      cap_en;
    cell_sel_t cap_sel;
    logic      deriv_en;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      comb_en;
    logic      comb2_en;
    logic      div_start;
    div_sel_t  div_sel;
    logic      div_store;
    logic      fin_en;
  } cmd_t;

  typedef struct packed {
    logic sub_en;
    logic d_zero;
    logic ratio_ok;
    logic div_done;
    logic out_valid;
    logic out_free;
    logic wchg;
  } sts_t;

  // Row step of a neighbor
  function automatic logic signed [1:0] cell_dr(cell_sel_t s);
    logic signed [1:0] r;
    unique case (s)
      CELL_M0, CELL_MP, CELL_MM: r = -2'sd1;
      CELL_P0, CELL_PP, CELL_PM: r = 2'sd1;
      default:                   r = 2'sd0;
    endcase
    return r;
  endfunction

  // Column step of a neighbor
  function automatic logic signed [1:0] cell_dc(cell_sel_t s);
    logic signed [1:0] r;
    unique case (s)
      CELL_0M, CELL_PM, CELL_MM: r = -2'sd1;
      CELL_0P, CELL_PP, CELL_MP: r = 2'sd1;
      default:                   r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/correlation_peak_subpixel_fit.sv */
// Top level of the correlation peak locator with quadratic sub-pixel fit.
// Depends on cpsf_pkg, cpsf_ctrl and cpsf_dp.
`timescale 1ns / 1ps

// Usage:
// Samples of the correlation map enter on the in_ channel in row-major order,
// one word per cycle, each with its x and y axis coordinate. A word is taken
// when in_valid is high and in_stall is low. The word with in_last set closes
// the map and starts the fit; one result word then leaves on the out_ channel
// and is taken when out_valid is high and out_stall is low.
// After the last sample, with the sub-pixel fit enabled, the fit reads the
// nine neighbors of the peak from the sample store (one port), runs eleven
// products through one shared multiplier and performs up to three divisions
// on a one-bit-per-cycle divider; without the fit it runs only the ratio
// product and at most the ratio division. in_stall is high throughout.
// The result sits in an output register; loading of the next map proceeds
// while it waits, and only that map's last word is held off until it is taken.
// A write to map_width while samples load makes the divider recompute the
// row and column of the current sample count, with the input stalled.
// Reset (rst_n low, synchronous) clears the map and restores the register
// defaults; the sample store holds no valid data until it has been loaded.

module correlation_peak_subpixel_fit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cpsf_pkg::CORR_W-1:0]  in_corr_value,
  input  logic signed [cpsf_pkg::AXIS_W-1:0]  in_x_axis_value,
  input  logic signed [cpsf_pkg::AXIS_W-1:0]  in_y_axis_value,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cpsf_pkg::AXIS_W-1:0]  out_disp_y,
  output logic signed [cpsf_pkg::AXIS_W-1:0]  out_disp_x,
  output logic signed [cpsf_pkg::CORR_W-1:0]  out_peak_ratio,
  output logic signed [cpsf_pkg::CORR_W-1:0]  out_peak_value,
  input  logic                                cfg_we,
  input  logic [cpsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpsf_pkg::CFG_W-1:0]          cfg_data
);
  import cpsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  cpsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  cpsf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_corr_value   (in_corr_value),
    .in_x_axis_value (in_x_axis_value),
    .in_y_axis_value (in_y_axis_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_disp_y      (out_disp_y),
    .out_disp_x      (out_disp_x),
    .out_peak_ratio  (out_peak_ratio),
    .out_peak_value  (out_peak_value)
  );

endmodule

/* hdl/cpsf_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on cpsf_pkg for its widths.
`timescale 1ns / 1ps

module cpsf_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cpsf_pkg::DIV_NW-1:0]   num,
  input  logic [cpsf_pkg::DIV_DW-1:0]   den,
  output logic                          busy,
  output logic                          done,
  output logic [cpsf_pkg::DIV_NW-1:0]   quo,
  output logic [cpsf_pkg::DIV_DW-1:0]   rem
);
  import cpsf_pkg::*;

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NW-1:0]    quo_r;
  logic [DIV_DW-1:0]    rem_r, den_r;
  logic [DIV_DW:0]      trial;
  logic                 ge;
  logic [DIV_DW:0]      diff;

  // Shift the next numerator bit into the partial remainder and try the subtract
  always_comb begin
    trial = {rem_r, quo_r[DIV_NW-1]};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* hdl/cpsf_ctrl.sv */
// Controller for the peak fit: sequences sample loading, neighbor reads,
// products, divisions and the result load. Depends on cpsf_pkg.
`timescale 1ns / 1ps

module cpsf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_stall,
  input  cpsf_pkg::sts_t sts,
  output cpsf_pkg::cmd_t cmd
);
  import cpsf_pkg::*;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  div_sel_t            dsel_r, dsel_nxt;
  logic                accept;
  logic [STEP_W-1:0]   step_m1;

  // A last word waits while the previous result is still held
  assign in_stall = (state_r != ST_LOAD) || (in_last && sts.out_valid);
  assign accept   = in_valid && !in_stall;
  assign step_m1  = step_r - 1'b1;

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    dsel_nxt  = dsel_r;
    unique case (state_r)
      ST_LOAD: begin
        if (sts.wchg) begin
          state_nxt = ST_WSTART;
          dsel_nxt  = DIV_ROWCOL;
        end else if (accept && in_last) begin
          step_nxt  = '0;
          state_nxt = sts.sub_en ? ST_READ : ST_RMUL;
        end
      end
      ST_READ: begin
        if (step_r == STEP_W'(READ_LAST)) begin
          state_nxt = ST_DERIV;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DERIV: begin
        state_nxt = ST_MUL;
        step_nxt  = STEP_W'(MUL_HXX_HYY);
      end
      ST_MUL: begin
        if (step_r == STEP_W'(MUL_HXY_GX)) begin
          state_nxt = ST_COMB;
        end else if (step_r == STEP_W'(MUL_NY_LO)) begin
          state_nxt = ST_RMUL;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_COMB: begin
        state_nxt = ST_MUL;
        step_nxt  = STEP_W'(MUL_NX_HI);
      end
      ST_RMUL: state_nxt = ST_COMB2;
      ST_COMB2: begin
        if (sts.sub_en && !sts.d_zero) begin
          state_nxt = ST_DSTART;
          dsel_nxt  = DIV_OX;
        end else if (sts.ratio_ok) begin
          state_nxt = ST_DSTART;
          dsel_nxt  = DIV_RATIO;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (sts.div_done) begin
          if (dsel_r == DIV_OX) begin
            state_nxt = ST_DSTART;
            dsel_nxt  = DIV_OY;
          end else if (dsel_r == DIV_OY && sts.ratio_ok) begin
            state_nxt = ST_DSTART;
            dsel_nxt  = DIV_RATIO;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (sts.out_free) state_nxt = ST_LOAD;
      end
      ST_WSTART: state_nxt = ST_WWAIT;
      ST_WWAIT: begin
        if (sts.div_done) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = CELL_00;
    cmd.cap_sel   = CELL_00;
    cmd.mul_sel   = MUL_HXX_HYY;
    cmd.div_sel   = dsel_r;
    cmd.sample_en = accept;
    cmd.fit_clr   = accept && in_last;
    unique case (state_r)
      ST_READ: begin
        cmd.rd_en   = step_r != STEP_W'(READ_LAST);
        cmd.rd_sel  = cell_sel_t'(step_r);
        cmd.cap_en  = step_r != '0;
        cmd.cap_sel = cell_sel_t'(step_m1);
      end
      ST_DERIV: cmd.deriv_en = 1'b1;
      ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mul_sel_t'(step_r);
      end
      ST_COMB:  cmd.comb_en = 1'b1;
      ST_RMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RATIO;
      end
      ST_COMB2: cmd.comb2_en = 1'b1;
      ST_DSTART, ST_WSTART: cmd.div_start = 1'b1;
      ST_DWAIT, ST_WWAIT:   cmd.div_store = sts.div_done;
      ST_FIN:   cmd.fin_en = sts.out_free;
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      step_r  <= '0;
      dsel_r  <= DIV_OX;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dsel_r  <= dsel_nxt;
    end
  end

  // A divider finish is only ever expected while waiting on it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_DWAIT || state_r == ST_WWAIT))
    else $error("divider finished outside a wait state");

  // Loading a result always returns to sample loading
  a_fin_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_en |=> state_r == ST_LOAD)
    else $error("result load did not return to loading");

endmodule

/* hdl/cpsf_dp.sv */
// Datapath of the peak fit: configuration, sample store, peak tracking,
// neighbor fit arithmetic, shared multiplier and divider, result register.
// Depends on cpsf_pkg and cpsf_div.
`timescale 1ns / 1ps

module cpsf_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  cpsf_pkg::cmd_t                         cmd,
  output cpsf_pkg::sts_t                         sts,
  input  logic signed [cpsf_pkg::CORR_W-1:0]     in_corr_value,
  input  logic signed [cpsf_pkg::AXIS_W-1:0]     in_x_axis_value,
  input  logic signed [cpsf_pkg::AXIS_W-1:0]     in_y_axis_value,
  input  logic                                   cfg_we,
  input  logic [cpsf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [cpsf_pkg::CFG_W-1:0]             cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cpsf_pkg::AXIS_W-1:0]     out_disp_y,
  output logic signed [cpsf_pkg::AXIS_W-1:0]     out_disp_x,
  output logic signed [cpsf_pkg::CORR_W-1:0]     out_peak_ratio,
  output logic signed [cpsf_pkg::CORR_W-1:0]     out_peak_value
);
  import cpsf_pkg::*;

  // Configuration
  logic [CFG_W-1:0] map_width_r, map_height_r;
  logic             sub_en_r;
  logic [CFG_W-1:0] w_eff, h_eff;
  logic [CNT_W-1:0] map_size;

  // Loading state
  logic [CORR_W-1:0]        mem [0:DEPTH-1];
  logic [CORR_W-1:0]        mem_q_r;
  logic [ROW_W-1:0]         row_r, peak_row_r;
  logic [COL_W-1:0]         col_r, peak_col_r;
  logic [CNT_W-1:0]         count_r;
  logic signed [CORR_W-1:0] max_r;
  logic [27:0]              abs_r, abs_nxt;
  logic signed [AXIS_W-1:0] x_at_peak_r, y_at_peak_r;
  logic signed [AXIS_W-1:0] xm_r [0:2];
  logic signed [AXIS_W-1:0] ym_r [0:2];
  logic                     full, take, col_last, row_last;
  logic [16:0]              abs_c;
  logic [28:0]              abs_sum;

  // Fit state
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [7:0]        rs, cs;
  logic [ROW_W-1:0]         rr;
  logic [COL_W-1:0]         cc;
  logic signed [CORR_W-1:0] c_r [0:8];
  logic signed [16:0]       gx_r, gy_r;
  logic signed [18:0]       hxx_r, hyy_r, hxy_r;
  logic signed [20:0]       mul_a;
  logic signed [24:0]       mul_b;
  logic signed [45:0]       prod;
  logic signed [45:0]       p_r [0:MUL_N-1];
  logic signed [24:0]       resx, resy;
  logic signed [47:0]       d_r, d_nxt, tx, ty;
  logic signed [39:0]       nxp_r, nyp_r;
  logic signed [63:0]       nx_r, ny_r, rnum_r;
  logic [CNT_W-1:0]         cnt_m1;
  logic signed [16:0]       max17, amax;
  logic signed [28:0]       rden;
  logic signed [OFF_W-1:0]  ox_r, oy_r;
  logic signed [CORR_W-1:0] ratio_r;

  // Divider
  logic signed [63:0]       dn;
  logic signed [47:0]       dd;
  logic [DIV_NW-1:0]        an, div_num, quo;
  logic [DIV_DW-1:0]        ad, rem;
  logic                     div_busy, div_done;
  div_sel_t                 div_sel_r;
  logic                     neg_r;
  logic [25:0]              qoff;
  logic signed [OFF_W-1:0]  off;
  logic signed [CORR_W-1:0] qrat;

  // Result
  logic                     out_valid_r;
  logic signed [AXIS_W-1:0] out_dy_r, out_dx_r;
  logic signed [CORR_W-1:0] out_ratio_r, out_peak_r;
  logic signed [OFF_W-1:0]  dx, dy, dx_c, dy_c;

  // Effective map size, saturated into the supported range
  always_comb begin
    w_eff = map_width_r;
    if (map_width_r < 7'd2) w_eff = 7'd2;
    else if (map_width_r > CFG_W'(MAX_WIDTH)) w_eff = CFG_W'(MAX_WIDTH);
    h_eff = map_height_r;
    if (map_height_r < 7'd2) h_eff = 7'd2;
    else if (map_height_r > CFG_W'(MAX_HEIGHT)) h_eff = CFG_W'(MAX_HEIGHT);
  end

  assign map_size = CNT_W'(w_eff * h_eff);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= CFG_W'(MAX_WIDTH);
      map_height_r <= CFG_W'(MAX_HEIGHT);
      sub_en_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width_r  <= cfg_data;
        CFG_MAP_HEIGHT: map_height_r <= cfg_data;
        CFG_SUB_PIXEL:  sub_en_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Per-sample bookkeeping
  always_comb begin
    full     = count_r >= map_size;
    take     = cmd.sample_en && !full;
    col_last = 7'(col_r) == (w_eff - 7'd1);
    row_last = 7'(row_r) == (h_eff - 7'd1);
    abs_c    = in_corr_value[CORR_W-1] ? 17'(-17'(in_corr_value)) : 17'(in_corr_value);
    abs_sum  = {1'b0, abs_r} + 29'(abs_c);
    abs_nxt  = abs_sum[28] ? '1 : abs_sum[27:0];
  end

  // Sample store, one write and one registered read
  always_ff @(posedge clk) begin
    if (take) mem[{row_r, col_r}] <= in_corr_value;
    if (cmd.rd_en) mem_q_r <= mem[rd_addr];
  end

  // Map tracking: position, peak, sum and axis values at the peak
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.fin_en) begin
      count_r     <= '0;
      row_r       <= '0;
      col_r       <= '0;
      max_r       <= {1'b1, {(CORR_W-1){1'b0}}};
      peak_row_r  <= '0;
      peak_col_r  <= '0;
      abs_r       <= '0;
      x_at_peak_r <= '0;
      y_at_peak_r <= '0;
    end else if (take) begin
      count_r <= count_r + 1'b1;
      if (col_last) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
      if (count_r == '0 || in_corr_value > max_r) begin
        max_r       <= in_corr_value;
        peak_row_r  <= row_r;
        peak_col_r  <= col_r;
        x_at_peak_r <= in_x_axis_value;
        y_at_peak_r <= in_y_axis_value;
      end
      abs_r <= abs_nxt;
    end else if (cmd.div_store && div_sel_r == DIV_ROWCOL) begin
      row_r <= quo[ROW_W-1:0];
      col_r <= rem[COL_W-1:0];
    end
  end

  // Axis marks survive the end of a map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        xm_r[i] <= '0;
        ym_r[i] <= '0;
      end
    end else if (take) begin
      if (row_r == '0 && col_r == '0) begin
        xm_r[0] <= in_x_axis_value;
        ym_r[0] <= in_y_axis_value;
      end
      if (row_r == '0 && col_r == COL_W'(1)) xm_r[1] <= in_x_axis_value;
      if (row_r == '0 && col_last) xm_r[2] <= in_x_axis_value;
      if (row_r == ROW_W'(1) && col_r == '0) ym_r[1] <= in_y_axis_value;
      if (row_last && col_r == '0) ym_r[2] <= in_y_axis_value;
    end
  end

  // Neighbor address, clamped into the map
  always_comb begin
    rs = $signed({2'b00, peak_row_r}) + 8'(cell_dr(cmd.rd_sel));
    cs = $signed({2'b00, peak_col_r}) + 8'(cell_dc(cmd.rd_sel));
    if (rs < 0) rr = '0;
    else if (rs > $signed({1'b0, h_eff - 7'd1})) rr = ROW_W'(h_eff - 7'd1);
    else rr = rs[ROW_W-1:0];
    if (cs < 0) cc = '0;
    else if (cs > $signed({1'b0, w_eff - 7'd1})) cc = COL_W'(w_eff - 7'd1);
    else cc = cs[COL_W-1:0];
    rd_addr = {rr, cc};
  end

  // Neighbor capture and gradient/curvature terms
  always_ff @(posedge clk) begin
    if (cmd.cap_en) c_r[cmd.cap_sel] <= mem_q_r;
    if (cmd.deriv_en) begin
      gy_r  <= 17'(c_r[CELL_P0]) - 17'(c_r[CELL_M0]);
      gx_r  <= 17'(c_r[CELL_0P]) - 17'(c_r[CELL_0M]);
      hyy_r <= 19'(c_r[CELL_P0]) + 19'(c_r[CELL_M0]) - (19'(c_r[CELL_00]) <<< 1);
      hxx_r <= 19'(c_r[CELL_0P]) + 19'(c_r[CELL_0M]) - (19'(c_r[CELL_00]) <<< 1);
      hxy_r <= 19'(c_r[CELL_PP]) - 19'(c_r[CELL_PM]) - 19'(c_r[CELL_MP])
             + 19'(c_r[CELL_MM]);
    end
  end

  // Shared multiplier operand selection
  assign resx   = 25'(xm_r[1]) - 25'(xm_r[0]);
  assign resy   = 25'(ym_r[1]) - 25'(ym_r[0]);
  assign cnt_m1 = count_r - 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      MUL_HXX_HYY: begin mul_a = 21'(hxx_r); mul_b = 25'(hyy_r); end
      MUL_HXY_SQ:  begin mul_a = 21'(hxy_r); mul_b = 25'(hxy_r); end
      MUL_HYY_GX:  begin mul_a = 21'(hyy_r); mul_b = 25'(gx_r);  end
      MUL_HXY_GY:  begin mul_a = 21'(hxy_r); mul_b = 25'(gy_r);  end
      MUL_HXX_GY:  begin mul_a = 21'(hxx_r); mul_b = 25'(gy_r);  end
      MUL_HXY_GX:  begin mul_a = 21'(hxy_r); mul_b = 25'(gx_r);  end
      MUL_NX_HI:   begin mul_a = 21'($signed(nxp_r[39:20])); mul_b = resx; end
      MUL_NX_LO:   begin mul_a = $signed({1'b0, nxp_r[19:0]}); mul_b = resx; end
      MUL_NY_HI:   begin mul_a = 21'($signed(nyp_r[39:20])); mul_b = resy; end
      MUL_NY_LO:   begin mul_a = $signed({1'b0, nyp_r[19:0]}); mul_b = resy; end
      MUL_RATIO:   begin mul_a = 21'(max_r); mul_b = $signed({12'd0, cnt_m1}); end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) p_r[cmd.mul_sel] <= prod;
  end

  // Determinant and offset numerators
  always_comb begin
    d_nxt = (48'(p_r[MUL_HXX_HYY]) <<< 4) - 48'(p_r[MUL_HXY_SQ]);
    tx    = (48'(p_r[MUL_HYY_GX]) <<< 2) - 48'(p_r[MUL_HXY_GY]);
    ty    = (48'(p_r[MUL_HXX_GY]) <<< 2) - 48'(p_r[MUL_HXY_GX]);
  end

  always_ff @(posedge clk) begin
    if (cmd.comb_en) begin
      d_r   <= d_nxt;
      nxp_r <= 40'(-(tx <<< 1));
      nyp_r <= 40'(-(ty <<< 1));
    end
    if (cmd.comb2_en) begin
      nx_r   <= (64'(p_r[MUL_NX_HI]) <<< 20) + 64'(p_r[MUL_NX_LO]);
      ny_r   <= (64'(p_r[MUL_NY_HI]) <<< 20) + 64'(p_r[MUL_NY_LO]);
      rnum_r <= 64'(p_r[MUL_RATIO]) <<< 8;
    end
  end

  // Ratio denominator: sum of magnitudes of the samples other than the peak
  always_comb begin
    max17 = 17'(max_r);
    amax  = max17[16] ? -max17 : max17;
    rden  = $signed({1'b0, abs_r}) - 29'(amax);
  end

  // Divider operands: magnitudes, with half the divisor added for rounding except for the row/column division
  always_comb begin
    dn = nx_r;
    dd = d_r;
    unique case (cmd.div_sel)
      DIV_OX:     begin dn = nx_r;   dd = d_r; end
      DIV_OY:     begin dn = ny_r;   dd = d_r; end
      DIV_RATIO:  begin dn = rnum_r; dd = 48'(rden); end
      DIV_ROWCOL: begin
        dn = $signed({{(64-CNT_W){1'b0}}, count_r});
        dd = $signed({{(48-CFG_W){1'b0}}, w_eff});
      end
      default: ;
    endcase
    an = dn[63] ? 64'(-dn) : 64'(dn);
    ad = dd[47] ? 48'(-dd) : 48'(dd);
    div_num = (cmd.div_sel == DIV_ROWCOL) ? an : an + 64'(ad[47:1]);
  end

  cpsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (ad),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo),
    .rem   (rem)
  );

  // Signed, saturated quotients
  always_comb begin
    qoff = (quo > 64'(OFF_LIM)) ? 26'(OFF_LIM) : quo[25:0];
    off  = neg_r ? -$signed({1'b0, qoff}) : $signed({1'b0, qoff});
    if (neg_r) qrat = (quo > 64'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, quo[15:0]}));
    else       qrat = (quo > 64'd32767) ? 16'sh7fff : $signed(quo[15:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
      neg_r     <= dn[63] ^ dd[47];
    end
    if (cmd.fit_clr) begin
      ox_r    <= '0;
      oy_r    <= '0;
      ratio_r <= '0;
    end else if (cmd.div_store) begin
      case (div_sel_r)
        DIV_OX:    ox_r    <= off;
        DIV_OY:    oy_r    <= off;
        DIV_RATIO: ratio_r <= qrat;
        default: ;
      endcase
    end
  end

  // Displacement clamped to the axis marks
  always_comb begin
    dx = OFF_W'(x_at_peak_r) + ox_r;
    dy = OFF_W'(y_at_peak_r) + oy_r;
    if (dx > OFF_W'(xm_r[2])) dx_c = OFF_W'(xm_r[2]);
    else if (dx < OFF_W'(xm_r[0])) dx_c = OFF_W'(xm_r[0]);
    else dx_c = dx;
    if (dy > OFF_W'(ym_r[2])) dy_c = OFF_W'(ym_r[2]);
    else if (dy < OFF_W'(ym_r[0])) dy_c = OFF_W'(ym_r[0]);
    else dy_c = dy;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.fin_en) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      out_dx_r    <= dx_c[AXIS_W-1:0];
      out_dy_r    <= dy_c[AXIS_W-1:0];
      out_ratio_r <= ratio_r;
      out_peak_r  <= max_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_disp_x     = out_dx_r;
  assign out_disp_y     = out_dy_r;
  assign out_peak_ratio = out_ratio_r;
  assign out_peak_value = out_peak_r;

  // Status to the controller
  always_comb begin
    sts           = '0;
    sts.sub_en    = sub_en_r;
    sts.d_zero    = d_r == '0;
    sts.ratio_ok  = (count_r > CNT_W'(1)) && (rden > 0);
    sts.div_done  = div_done;
    sts.out_valid = out_valid_r;
    sts.out_free  = !out_valid_r || !out_stall;
    sts.wchg      = cfg_we && cfg_index == CFG_MAP_WIDTH;
  end

  // The divider is never restarted while it is still iterating
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  // A new result appears only from a result load
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.fin_en))
    else $error("result word appeared without a load");

  // Each result starts a fresh map
  a_map_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_en |=> count_r == '0)
    else $error("map state not cleared after a result");

endmodule
